[rtl/core/axis_angle_rotation_matrix_macros.svh]
// assertion macros for the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

`define AARM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AARM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/aarm_pkg.sv]
package aarm_pkg;

  localparam int CW           = 34;
  localparam int STEPS        = 30;
  localparam int TRIG_BITS    = 30;
  localparam int AXW          = 16;
  localparam int PW           = 32;
  localparam int MW           = 66;
  localparam int TW           = 68;
  localparam int QDEPTH       = 4;
  localparam int QAW          = 2;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic signed [AXW-1:0] ax;
    logic signed [AXW-1:0] ay;
    logic signed [AXW-1:0] az;
    logic signed [CW-1:0]  ang;
    logic                  flip;
    logic signed [PW-1:0]  pxx;
    logic signed [PW-1:0]  pyy;
    logic signed [PW-1:0]  pzz;
    logic signed [PW-1:0]  pxy;
    logic signed [PW-1:0]  pxz;
    logic signed [PW-1:0]  pyz;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pop;
  } qstat_t;

  function automatic cval_t atan_turn(input int i);
    cval_t r;
    unique case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/aarm_front.sv]
module aarm_front
  import aarm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  output logic        push,
  output item_t       push_item,
  input  logic        q_full
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic signed [AXW-1:0] a;
  logic signed [AXW:0]   ared;
  logic                  flip;

  assign push      = valid_r && !q_full;
  assign in_tready = !valid_r || !q_full;
  assign push_item = item_r;

  always_comb begin
    a = $signed(in_tdata[63:48]);
    flip = 1'b0;
    ared = {a[AXW-1], a};
    if (a > 16'sd16384) begin
      ared = ared - 17'sd32768;
      flip = 1'b1;
    end else if (a < -16'sd16384) begin
      ared = ared + 17'sd32768;
      flip = 1'b1;
    end
    item_nxt.ax   = $signed(in_tdata[15:0]);
    item_nxt.ay   = $signed(in_tdata[31:16]);
    item_nxt.az   = $signed(in_tdata[47:32]);
    item_nxt.ang  = CW'($signed({ared, 16'h0000}));
    item_nxt.flip = flip;
    item_nxt.pxx  = item_nxt.ax * item_nxt.ax;
    item_nxt.pyy  = item_nxt.ay * item_nxt.ay;
    item_nxt.pzz  = item_nxt.az * item_nxt.az;
    item_nxt.pxy  = item_nxt.ax * item_nxt.ay;
    item_nxt.pxz  = item_nxt.ax * item_nxt.az;
    item_nxt.pyz  = item_nxt.ay * item_nxt.az;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/core/aarm_queue.sv]
module aarm_queue
  import aarm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t stat
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;

  assign head       = mem[rp_r];
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.pop   = pop;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

[rtl/core/aarm_back.sv]
module aarm_back
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  item_t        head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata
);

  logic adv;
  logic  v_r   [STEPS+1];
  cval_t cx_r  [STEPS+1];
  cval_t cy_r  [STEPS+1];
  cval_t cz_r  [STEPS+1];
  item_t it_r  [STEPS+1];

  logic  m1_v_r;
  cval_t m1_c_r, m1_s_r, m1_omc_r;
  item_t m1_it_r;

  logic  m2_v_r;
  logic signed [MW-1:0] m2_xx_r, m2_yy_r, m2_zz_r, m2_xy_r, m2_xz_r, m2_yz_r;
  logic signed [TW-1:0] m2_sx_r, m2_sy_r, m2_sz_r, m2_cd_r;

  logic         ov_r;
  logic [143:0] od_r;
  logic [143:0] od_nxt;

  assign adv        = !ov_r || out_tready;
  assign pop        = adv && !q_empty;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  function automatic logic [15:0] fin(input logic signed [MW-1:0] m,
                                      input logic signed [TW-1:0] extra);
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] r;
    logic [15:0]          o;
    t = (TW'(m) >>> FRAC_BITS) + extra;
    r = (t + (TW'(1) <<< (TRIG_BITS-1))) >>> TRIG_BITS;
    if (r > TW'(32767))       o = 16'h7fff;
    else if (r < -TW'(32768)) o = 16'h8000;
    else                      o = r[15:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= GAIN_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= head.ang;
      it_r[0] <= head;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    cval_t dx, dy;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[i+1] <= it_r[i];
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - atan_turn(i);
        end else begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else if (adv) begin
      m1_v_r <= v_r[STEPS];
      m2_v_r <= m1_v_r;
      ov_r   <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_it_r  <= it_r[STEPS];
      m1_c_r   <= it_r[STEPS].flip ? -cx_r[STEPS] : cx_r[STEPS];
      m1_s_r   <= it_r[STEPS].flip ? -cy_r[STEPS] : cy_r[STEPS];
      m1_omc_r <= (CW'(1) <<< TRIG_BITS)
                  - (it_r[STEPS].flip ? -cx_r[STEPS] : cx_r[STEPS]);

      m2_xx_r <= MW'(m1_it_r.pxx) * MW'(m1_omc_r);
      m2_yy_r <= MW'(m1_it_r.pyy) * MW'(m1_omc_r);
      m2_zz_r <= MW'(m1_it_r.pzz) * MW'(m1_omc_r);
      m2_xy_r <= MW'(m1_it_r.pxy) * MW'(m1_omc_r);
      m2_xz_r <= MW'(m1_it_r.pxz) * MW'(m1_omc_r);
      m2_yz_r <= MW'(m1_it_r.pyz) * MW'(m1_omc_r);
      m2_sx_r <= TW'(m1_it_r.ax) * TW'(m1_s_r);
      m2_sy_r <= TW'(m1_it_r.ay) * TW'(m1_s_r);
      m2_sz_r <= TW'(m1_it_r.az) * TW'(m1_s_r);
      m2_cd_r <= TW'(m1_c_r) <<< FRAC_BITS;

      od_r <= od_nxt;
    end
  end

  always_comb begin
    od_nxt[15:0]    = fin(m2_xx_r, m2_cd_r);
    od_nxt[31:16]   = fin(m2_xy_r, m2_sz_r);
    od_nxt[47:32]   = fin(m2_xz_r, -m2_sy_r);
    od_nxt[63:48]   = fin(m2_xy_r, -m2_sz_r);
    od_nxt[79:64]   = fin(m2_yy_r, m2_cd_r);
    od_nxt[95:80]   = fin(m2_yz_r, m2_sx_r);
    od_nxt[111:96]  = fin(m2_xz_r, m2_sy_r);
    od_nxt[127:112] = fin(m2_yz_r, -m2_sx_r);
    od_nxt[143:128] = fin(m2_zz_r, m2_cd_r);
  end

endmodule

[rtl/core/axis_angle_rotation_matrix.sv]
// channel  dir  tdata fields (low bit up)
// in_      in   axis_x, axis_y, axis_z, turn_angle (64 bits)
// out_     out  m_c0_r0, m_c1_r0, m_c2_r0, m_c0_r1, m_c1_r1, m_c2_r1,
//               m_c0_r2, m_c1_r2, m_c2_r2 (144 bits)
// One word accepted per cycle while the queue has room; the pipeline is the
// 30-stage CORDIC rotator plus the product and rounding stages.
// Synchronous active-low reset clears all valid state; no clearing pass.
// An output stall freezes the back pipeline; the 4-entry queue and the
// front register keep taking words until they fill.
`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // axis_x, axis_y, axis_z, turn_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m_c0_r0 .. m_c2_r2, column first then row
);

  logic   push;
  item_t  push_item;
  item_t  head;
  logic   pop;
  qstat_t qstat;

  aarm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (qstat.full)
  );

  aarm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  aarm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (qstat.empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `AARM_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "output valid after reset")
  `AARM_ASSERT(a_q_sane, !(qstat.full && qstat.empty), "queue full and empty")
  `AARM_ASSERT(a_pop_ok, qstat.pop |-> !qstat.empty, "pop from empty queue")

endmodule
